// ===== src/tkh_pkg.sv =====
package tkh_pkg;

  localparam int TKH_TOP_K = 10;
  localparam int COUNT_W   = 32;
  localparam int KEY_W     = 64;
  localparam int SLOT_W    = 4;
  localparam int ENTRY_W   = COUNT_W + KEY_W;

  // one result item handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  index;
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0]   key;
    logic               final_slot;
  } emit_t;

endpackage

// ===== src/tkh_cmp.sv =====
module tkh_cmp #(
  parameter int PW = 5
) (
  input  logic [tkh_pkg::COUNT_W-1:0] cand_count,
  input  logic [tkh_pkg::KEY_W-1:0]   cand_key,
  input  logic [PW-1:0]               cand_pos,
  input  logic [tkh_pkg::COUNT_W-1:0] best_count,
  input  logic [tkh_pkg::KEY_W-1:0]   best_key,
  input  logic [PW-1:0]               best_pos,
  output logic [tkh_pkg::COUNT_W-1:0] sel_count,
  output logic [tkh_pkg::KEY_W-1:0]   sel_key,
  output logic [PW-1:0]               sel_pos
);
  import tkh_pkg::*;

  logic take;

  // strictly smaller child wins, ties keep the current best
  assign take = cand_count < best_count;

  always_comb begin
    if (take) begin
      sel_count = cand_count;
      sel_key   = cand_key;
      sel_pos   = cand_pos;
    end else begin
      sel_count = best_count;
      sel_key   = best_key;
      sel_pos   = best_pos;
    end
  end

endmodule

// ===== src/tkh_ctrl.sv =====
module tkh_ctrl #(
  parameter int TOP_K = tkh_pkg::TKH_TOP_K
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tkh_pkg::COUNT_W-1:0] in_count,
  input  logic [tkh_pkg::KEY_W-1:0]   in_key,
  input  logic                        in_last,
  input  logic                        out_free,
  output tkh_pkg::emit_t              emit
);
  import tkh_pkg::*;

  localparam int AW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int PW = $clog2(2 * TOP_K + 2);
  localparam int CW = $clog2(TOP_K + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HLOAD, S_HCAP, S_RDL, S_RDR, S_RCMP, S_MOVE, S_NEXT, S_EMRD, S_EMLD
  } state_t;

  state_t              state;
  logic [CW-1:0]       fill;
  logic [CW-1:0]       n_emit;
  logic [AW-1:0]       ei;
  logic [PW-1:0]       hp;
  logic [PW-1:0]       pos;
  logic                heapify;
  logic                last_r;
  logic [COUNT_W-1:0]  mc;
  logic [KEY_W-1:0]    mk;
  logic [COUNT_W-1:0]  bc;
  logic [KEY_W-1:0]    bk;
  logic [PW-1:0]       bm;
  logic [COUNT_W-1:0]  root_cnt;

  logic [ENTRY_W-1:0]  mem [TOP_K];
  logic [ENTRY_W-1:0]  rdata;
  logic [AW-1:0]       rd_addr;
  logic                we;
  logic [AW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  logic [PW-1:0]       lpos;
  logic [PW-1:0]       rpos;
  logic [COUNT_W-1:0]  cmp_best_count;
  logic [KEY_W-1:0]    cmp_best_key;
  logic [PW-1:0]       cmp_best_pos;
  logic [COUNT_W-1:0]  sel_count;
  logic [KEY_W-1:0]    sel_key;
  logic [PW-1:0]       sel_pos;
  logic                emit_final;

  assign lpos = {pos[PW-2:0], 1'b0};
  assign rpos = lpos + PW'(1);
  assign in_ready = (state == S_IDLE);

  // left child against the moving entry, then right child against the winner
  always_comb begin
    if (state == S_RDR) begin
      cmp_best_count = mc;
      cmp_best_key   = mk;
      cmp_best_pos   = pos;
    end else begin
      cmp_best_count = bc;
      cmp_best_key   = bk;
      cmp_best_pos   = bm;
    end
  end

  tkh_cmp #(.PW(PW)) u_cmp (
    .cand_count (rdata[COUNT_W-1:0]),
    .cand_key   (rdata[ENTRY_W-1:COUNT_W]),
    .cand_pos   ((state == S_RDR) ? lpos : rpos),
    .best_count (cmp_best_count),
    .best_key   (cmp_best_key),
    .best_pos   (cmp_best_pos),
    .sel_count  (sel_count),
    .sel_key    (sel_key),
    .sel_pos    (sel_pos)
  );

  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = '0;
    wr_data = {in_key, in_count};
    unique case (state)
      S_IDLE: begin
        we      = in_valid && (fill < CW'(TOP_K));
        wr_addr = AW'(fill);
      end
      S_HLOAD: rd_addr = AW'(hp - PW'(1));
      S_RDL:   rd_addr = AW'(lpos - PW'(1));
      S_RDR:   rd_addr = AW'(lpos);
      S_MOVE: begin
        we      = 1'b1;
        wr_addr = AW'(pos - PW'(1));
        wr_data = (bm == pos) ? {mk, mc} : {bk, bc};
      end
      // slot address held while the result waits for the output register
      S_EMRD, S_EMLD: rd_addr = ei;
      default: rd_addr = '0;
    endcase
  end

  // heap store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // root count shadow so the replace decision needs no heap memory read
  always_ff @(posedge clk) begin
    if (we && wr_addr == '0) begin
      root_cnt <= wr_data[COUNT_W-1:0];
    end
  end

  assign emit_final = (CW'(ei) + CW'(1)) == n_emit;

  always_comb begin
    emit.valid      = (state == S_EMLD);
    emit.index      = SLOT_W'(ei);
    emit.count      = rdata[COUNT_W-1:0];
    emit.key        = rdata[ENTRY_W-1:COUNT_W];
    emit.final_slot = emit_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_r  <= in_last;
            heapify <= 1'b0;
            ei      <= '0;
            if (fill < CW'(TOP_K)) begin
              fill <= fill + CW'(1);
              if ((fill + CW'(1)) == CW'(TOP_K) && TOP_K > 1) begin
                heapify <= 1'b1;
                hp      <= PW'(TOP_K / 2);
                state   <= S_HLOAD;
              end else if (in_last) begin
                n_emit <= fill + CW'(1);
                state  <= S_EMRD;
              end
            end else if (in_count > root_cnt) begin
              mc    <= in_count;
              mk    <= in_key;
              pos   <= PW'(1);
              state <= S_RDL;
            end else if (in_last) begin
              n_emit <= fill;
              state  <= S_EMRD;
            end
          end
        end
        S_HLOAD: state <= S_HCAP;
        S_HCAP: begin
          mc    <= rdata[COUNT_W-1:0];
          mk    <= rdata[ENTRY_W-1:COUNT_W];
          pos   <= hp;
          state <= S_RDL;
        end
        S_RDL: begin
          if (lpos > PW'(TOP_K)) begin
            bm    <= pos;
            state <= S_MOVE;
          end else begin
            state <= S_RDR;
          end
        end
        S_RDR: begin
          bc <= sel_count;
          bk <= sel_key;
          bm <= sel_pos;
          if (rpos > PW'(TOP_K)) begin
            state <= S_MOVE;
          end else begin
            state <= S_RCMP;
          end
        end
        S_RCMP: begin
          bc    <= sel_count;
          bk    <= sel_key;
          bm    <= sel_pos;
          state <= S_MOVE;
        end
        S_MOVE: begin
          if (bm == pos) begin
            state <= S_NEXT;
          end else begin
            pos   <= bm;
            state <= S_RDL;
          end
        end
        S_NEXT: begin
          if (heapify && hp > PW'(1)) begin
            hp    <= hp - PW'(1);
            state <= S_HLOAD;
          end else if (last_r) begin
            n_emit <= fill;
            ei     <= '0;
            state  <= S_EMRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMRD: state <= S_EMLD;
        S_EMLD: begin
          if (out_free) begin
            if (emit_final) begin
              fill  <= '0;
              state <= S_IDLE;
            end else begin
              ei    <= ei + AW'(1);
              state <= S_EMRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/top_k_min_heap_select.sv =====
// an item that is stored or dropped is handled in S_IDLE; a root replace walks the heap
//   level by level through S_RDL, S_RDR, S_RCMP and S_MOVE
// the TOP_K-th item builds the heap by sifting down each of the TOP_K/2 parent nodes
// a last item then emits its results through S_EMRD and S_EMLD, one heap memory read per cycle
// throughput: one item at a time, ready only between items; the output register frees
//   s_tready while the last result waits; reset clears control and fill count only
module top_k_min_heap_select #(
  parameter int TOP_K = tkh_pkg::TKH_TOP_K
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // hit_count[31:0], entry_key[95:32]
  input  logic         s_tlast,   // last_entry
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // slot_index[3:0], slot_count[35:4], slot_key[99:36], zero
  output logic         m_tlast    // final_slot
);
  import tkh_pkg::*;

  emit_t emit;
  logic  out_free;

  // output register can take a new item when empty or being drained
  assign out_free = !m_tvalid || m_tready;

  tkh_ctrl #(.TOP_K(TOP_K)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_count (s_tdata[COUNT_W-1:0]),
    .in_key   (s_tdata[ENTRY_W-1:COUNT_W]),
    .in_last  (s_tlast),
    .out_free (out_free),
    .emit     (emit)
  );

  // result item register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      m_tdata <= {4'b0000, emit.key, emit.count, emit.index};
      m_tlast <= emit.final_slot;
    end
  end

  // no result is offered while the block is taking items
  a_emit_not_ready: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> !s_tready)
    else $error("result offered while accepting items");

  // an accepted item never produces a result in the very next cycle
  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !emit.valid)
    else $error("result offered right after an item");

  // a result loaded into a free output register shows up as valid
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && out_free) |=> m_tvalid)
    else $error("result lost at output register");

endmodule

// ===== tb/sv/top_k_min_heap_select_test.sv =====
`timescale 1ns / 100ps

module top_k_min_heap_select_test;
  import tkh_pkg::*;

  // one entry of the input stream
  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0]   key;
    logic               is_last;
    bit                 wait_idle;   // hold back until every pending slot has come out
  } entry_t;

  // one emitted heap slot
  typedef struct {
    logic [SLOT_W-1:0]  index;
    logic [COUNT_W-1:0] count;
    logic [KEY_W-1:0]   key;
    logic               fin;
  } slot_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;   // hit_count[31:0], entry_key[95:32]
  logic         s_tlast = 1'b0; // last_entry
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // slot_index[3:0], slot_count[35:4], slot_key[99:36], zero
  logic         m_tlast;        // final_slot

  top_k_min_heap_select dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // predicted heap contents
  logic [COUNT_W-1:0] heap_cnt [TKH_TOP_K];
  logic [KEY_W-1:0]   heap_key [TKH_TOP_K];
  int                 heap_fill = 0;

  entry_t      entry_backlog[$];
  slot_t       slots_due[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;

  // handshake flags passed from the sampling edge to the driving edge
  bit took_in = 1'b0;
  bit took_out = 1'b0;
  bit got_fin = 1'b0;

  // sender state
  bit tx_busy = 1'b0;
  bit tx_burst = 1'b0;
  int tx_gap = 0;

  // receiver state
  bit rx_burst = 1'b0;
  bit late_hold_done = 1'b0;
  int rx_stall = 0;
  int hold_left = 0;

  // 1-based sift-down; ties never swap, left child wins over an equal right one
  function automatic void sink_slot(int pos, int len);
    int l;
    int r;
    int m;
    logic [COUNT_W-1:0] tc;
    logic [KEY_W-1:0]   tk;
    while (pos >= 1 && pos <= len) begin
      l = 2 * pos;
      r = l + 1;
      m = pos;
      if (l <= len) begin
        if (heap_cnt[l-1] < heap_cnt[pos-1]) m = l;
      end
      if (r <= len) begin
        if (heap_cnt[r-1] < heap_cnt[m-1]) m = r;
      end
      if (m == pos) break;
      tc = heap_cnt[pos-1];
      tk = heap_key[pos-1];
      heap_cnt[pos-1] = heap_cnt[m-1];
      heap_key[pos-1] = heap_key[m-1];
      heap_cnt[m-1] = tc;
      heap_key[m-1] = tk;
      pos = m;
    end
  endfunction

  // folds one accepted entry into the heap and queues the slots it releases
  function automatic void absorb_entry(logic [COUNT_W-1:0] c, logic [KEY_W-1:0] k,
                                       logic is_last);
    slot_t s;
    if (heap_fill < TKH_TOP_K) begin
      heap_cnt[heap_fill] = c;
      heap_key[heap_fill] = k;
      heap_fill++;
      if (heap_fill == TKH_TOP_K) begin
        for (int i = TKH_TOP_K / 2; i >= 1; i--) sink_slot(i, TKH_TOP_K);
      end
    end else if (c > heap_cnt[0]) begin
      heap_cnt[0] = c;
      heap_key[0] = k;
      sink_slot(1, TKH_TOP_K);
    end
    if (is_last) begin
      for (int i = 0; i < heap_fill; i++) begin
        s.index = i[SLOT_W-1:0];
        s.count = heap_cnt[i];
        s.key   = heap_key[i];
        s.fin   = (i + 1 == heap_fill);
        slots_due.push_back(s);
      end
      heap_fill = 0;
    end
  endfunction

  function automatic void queue_entry(logic [COUNT_W-1:0] c, logic [KEY_W-1:0] k,
                                      logic is_last, bit wait_idle);
    entry_t e;
    e.count     = c;
    e.key       = k;
    e.is_last   = is_last;
    e.wait_idle = wait_idle;
    entry_backlog.push_back(e);
  endfunction

  // sampling side: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    slot_t got;
    slot_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[3:0];
        got.count = m_tdata[35:4];
        got.key   = m_tdata[99:36];
        got.fin   = m_tlast;
        results_seen++;
        got_fin  = got.fin;
        took_out = 1'b1;
        if (slots_due.size() == 0) begin
          $error("unexpected slot: index %0d count %0h key %0h",
                 got.index, got.count, got.key);
          fail_count++;
        end else begin
          want = slots_due.pop_front();
          if (got.index !== want.index) begin
            $error("slot_index mismatch: expected %0d, got %0d", want.index, got.index);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $error("slot_count mismatch: expected %0h, got %0h", want.count, got.count);
            fail_count++;
          end
          if (got.key !== want.key) begin
            $error("slot_key mismatch: expected %0h, got %0h", want.key, got.key);
            fail_count++;
          end
          if (got.fin !== want.fin) begin
            $error("final_slot mismatch: expected %0b, got %0b", want.fin, got.fin);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        absorb_entry(s_tdata[31:0], s_tdata[95:32], s_tlast);
        took_in = 1'b1;
      end
    end
  end

  // sender: random gap before each item, occasional stretches without gaps
  always @(negedge clk) begin
    entry_t e;
    if (!rst) begin
      if (took_in) begin
        took_in = 1'b0;
        tx_busy = 1'b0;
        tx_gap  = tx_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (entry_backlog.size() != 0 &&
                     !(entry_backlog[0].wait_idle && slots_due.size() != 0)) begin
          e = entry_backlog.pop_front();
          s_tdata <= {e.key, e.count};
          s_tlast <= e.is_last;
          tx_busy = 1'b1;
        end
      end
      s_tvalid <= tx_busy;
    end
  end

  // receiver: random stall after each item, two long holds in the middle of a run
  always @(negedge clk) begin
    if (!rst) begin
      if (took_out) begin
        took_out = 1'b0;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        if (!got_fin && (results_seen == 5 || (results_seen >= 60 && !late_hold_done))) begin
          hold_left = 300;
          if (results_seen >= 60) late_hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int made;
    int len;
    int sel;
    bit narrow;
    logic [COUNT_W-1:0] c;

    // lone entry marked last: a single slot, extremes at zero
    queue_entry('0, '0, 1'b1, 1'b0);
    // short stream comes out in arrival order
    queue_entry('1, '1, 1'b0, 1'b0);
    queue_entry(32'd0, 64'h0123_4567_89ab_cdef, 1'b1, 1'b0);
    // full stream: heap build, top-bit count compared unsigned, equal-to-root drop,
    // then a max count replacing the root on the last entry
    queue_entry(32'h8000_0000, 64'h1000, 1'b0, 1'b0);
    for (int j = 9; j >= 1; j--) queue_entry(j, 64'h1000 + j, 1'b0, 1'b0);
    queue_entry(32'd1, 64'h2000, 1'b0, 1'b0);
    queue_entry('1, '1, 1'b1, 1'b0);
    // exactly TOP_K equal counts, offered while the first long hold stalls the output:
    // ties never swap
    for (int j = 0; j < TKH_TOP_K; j++)
      queue_entry(32'd5, 64'h3000 + j, j == TKH_TOP_K - 1, 1'b0);

    // random streams: mostly past the fill point, some short, some exactly full
    made = 0;
    while (made < 200) begin
      sel    = $urandom_range(0, 9);
      len    = (sel < 2) ? $urandom_range(1, TKH_TOP_K - 1) :
               (sel == 2) ? TKH_TOP_K : $urandom_range(TKH_TOP_K + 1, 30);
      narrow = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < len; j++) begin
        sel = $urandom_range(0, 15);
        if (narrow) c = $urandom_range(0, 7);
        else if (sel == 0) c = '0;
        else if (sel == 1) c = '1;
        else c = $urandom;
        queue_entry(c, {$urandom, $urandom}, j == len - 1,
                    j == 0 && (made == 0 || $urandom_range(0, 4) == 0));
      end
      made += len;
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (entry_backlog.size() != 0 || tx_busy) @(posedge clk);
    while (slots_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
